FILE: hw/rtl/pcts_pkg.sv
// Shared types and constants for the periodic CAN transmit scheduler.
package pcts_pkg;
	localparam int PortsDef = 8;
	localparam int QueueDepthDef = 4;
	localparam int IdW = 11;
	localparam int PeriodW = 16;
	localparam int DataW = 64;
	localparam int TimeW = 32;
	localparam int CntW = 16;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SET_EN = 3'd1;
	localparam logic [2:0] CMD_SET_MODE = 3'd2;
	localparam logic [2:0] CMD_QUERY = 3'd3;
	localparam logic [2:0] CMD_POLL = 3'd4;
	localparam logic [2:0] CMD_DRAIN = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_QFULL = 2'd3;

	localparam logic [TimeW-1:0] US_PER_MS = 32'd1000;

	// item handed from front to back
	typedef struct packed {
		logic [2:0] cmd;
		logic [IdW-1:0] tx_id;
		logic [PeriodW-1:0] period_ms;
		logic [7:0] start_index;
		logic [3:0] byte_count;
		logic [DataW-1:0] data;
		logic enable_value;
		logic single_mode;
		logic [TimeW-1:0] now_us;
	} cmd_item_t;
endpackage

FILE: hw/rtl/pcts_front.sv
// Command front end: takes commands and holds them in a short queue.
module pcts_front #(
	parameter int Depth = 2
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input pcts_pkg::cmd_item_t item,
	output logic item_valid,
	output pcts_pkg::cmd_item_t item_head,
	input logic item_pop
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	pcts_pkg::cmd_item_t fifo_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push;

	assign busy = (cnt_q == (AW+1)'(Depth));
	assign push = start && !busy;
	assign item_valid = (cnt_q != '0);
	assign item_head = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (item_pop) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(item_pop);
		end
	end
endmodule

FILE: hw/rtl/pcts_back.sv
// Command executor: port table walk, transmit queue and result generation.
module pcts_back #(
	parameter int Ports = pcts_pkg::PortsDef,
	parameter int QueueDepth = pcts_pkg::QueueDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic auto_tx_enable,
	input logic item_valid,
	input pcts_pkg::cmd_item_t item_head,
	output logic item_pop,
	output logic res_valid,
	output logic [1:0] status,
	output logic frame_valid,
	output logic [pcts_pkg::IdW-1:0] frame_id,
	output logic [pcts_pkg::DataW-1:0] frame_data,
	output logic [pcts_pkg::TimeW-1:0] interval_us,
	output logic port_enabled,
	output logic ready_res,
	output logic last,
	output logic [pcts_pkg::CntW-1:0] error_count
);
	localparam int PW = (Ports > 1) ? $clog2(Ports) : 1;
	localparam int QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

	typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EXEC, S_POLL, S_DRAIN, S_DONE} state_t;
	state_t state_q;

	logic [Ports-1:0] valid_q;
	logic [pcts_pkg::IdW-1:0] id_q [Ports];
	logic [pcts_pkg::PeriodW-1:0] per_q [Ports];
	logic [pcts_pkg::TimeW-1:0] lt_q [Ports];
	logic [Ports-1:0] en_q, sgl_q;
	logic [pcts_pkg::DataW-1:0] buf_q [Ports];
	logic [PW:0] total_q;
	logic [PW-1:0] slot_q [QueueDepth];
	logic [QW:0] fill_q;
	logic [pcts_pkg::CntW-1:0] ovf_q;

	pcts_pkg::cmd_item_t cur_q;
	logic [PW:0] idx_q;
	logic [PW-1:0] hit_q;
	logic [1:0] pst_q;
	logic rdy_q;

	logic [PW-1:0] ip;
	logic [pcts_pkg::TimeW-1:0] elapsed, thresh;
	logic due;
	logic [pcts_pkg::DataW-1:0] newbuf;
	logic rng;
	logic [PW-1:0] hs;

	assign ip = idx_q[PW-1:0];
	assign elapsed = cur_q.now_us - lt_q[ip];
	assign thresh = ({16'd0, per_q[ip]} - 32'd1) * pcts_pkg::US_PER_MS;
	assign due = valid_q[ip] && en_q[ip] && (elapsed >= thresh);
	assign hs = slot_q[0];
	assign error_count = ovf_q;

	// byte insert for add
	always_comb begin
		logic [8:0] pos;
		newbuf = buf_q[hit_q];
		rng = 1'b0;
		for (int i = 0; i < 8; i++) begin
			pos = {1'b0, cur_q.start_index} + 9'(i);
			if (4'(i) < cur_q.byte_count) begin
				if (pos >= 9'd8) rng = 1'b1;
				else newbuf[pos[2:0]*8 +: 8] = cur_q.data[i*8 +: 8];
			end
		end
		if (cur_q.byte_count > 4'd8) rng = 1'b1;
	end

	assign item_pop = (state_q == S_IDLE) && item_valid;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) cur_q <= item_head;
		if (state_q == S_LOOK && idx_q == total_q && total_q != (PW+1)'(Ports)) begin
			id_q[ip] <= cur_q.tx_id;
			per_q[ip] <= cur_q.period_ms;
			lt_q[ip] <= '0;
			buf_q[ip] <= '0;
		end
		if (state_q == S_EXEC && cur_q.cmd == pcts_pkg::CMD_ADD) begin
			buf_q[hit_q] <= newbuf;
			if (cur_q.period_ms < per_q[hit_q]) per_q[hit_q] <= cur_q.period_ms;
		end
		if (state_q == S_POLL && idx_q < total_q && due && fill_q < (QW+1)'(QueueDepth))
			slot_q[fill_q[QW-1:0]] <= ip;
		if (state_q == S_DRAIN && fill_q != '0) begin
			for (int i = 0; i + 1 < QueueDepth; i++) slot_q[i] <= slot_q[i+1];
			lt_q[hs] <= cur_q.now_us;
			frame_id <= id_q[hs];
			frame_data <= buf_q[hs];
			interval_us <= cur_q.now_us - lt_q[hs];
		end else if (res_valid || state_q != S_DRAIN) begin
			frame_id <= '0;
			frame_data <= '0;
			interval_us <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			en_q <= '0;
			sgl_q <= '0;
			total_q <= '0;
			fill_q <= '0;
			ovf_q <= '0;
			idx_q <= '0;
			hit_q <= '0;
			pst_q <= pcts_pkg::ST_OK;
			rdy_q <= 1'b0;
			res_valid <= 1'b0;
			status <= pcts_pkg::ST_OK;
			frame_valid <= 1'b0;
			port_enabled <= 1'b0;
			ready_res <= 1'b0;
			last <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					pst_q <= pcts_pkg::ST_OK;
					rdy_q <= 1'b0;
					if (item_valid) begin
						if (item_head.cmd <= pcts_pkg::CMD_QUERY) state_q <= S_LOOK;
						else if (item_head.cmd == pcts_pkg::CMD_POLL) state_q <= S_POLL;
						else if (item_head.cmd == pcts_pkg::CMD_DRAIN) state_q <= S_DRAIN;
						else state_q <= S_DONE;
					end
				end
				S_LOOK: begin
					// one table entry per cycle; create at the end
					if (idx_q == total_q) begin
						if (total_q == (PW+1)'(Ports)) begin
							pst_q <= pcts_pkg::ST_FULL;
							state_q <= S_DONE;
						end else begin
							valid_q[ip] <= 1'b1;
							en_q[ip] <= 1'b1;
							sgl_q[ip] <= 1'b0;
							total_q <= total_q + 1'b1;
							hit_q <= ip;
							state_q <= S_EXEC;
						end
					end else if (valid_q[ip] && id_q[ip] == cur_q.tx_id) begin
						hit_q <= ip;
						state_q <= S_EXEC;
					end else idx_q <= idx_q + 1'b1;
				end
				S_EXEC: begin
					case (cur_q.cmd)
						pcts_pkg::CMD_ADD: if (rng) pst_q <= pcts_pkg::ST_RANGE;
						pcts_pkg::CMD_SET_EN: en_q[hit_q] <= cur_q.enable_value;
						pcts_pkg::CMD_SET_MODE: sgl_q[hit_q] <= cur_q.single_mode;
						default: rdy_q <= en_q[hit_q];
					endcase
					state_q <= S_DONE;
				end
				S_POLL: begin
					if (!auto_tx_enable || idx_q >= total_q) state_q <= S_DONE;
					else begin
						if (due) begin
							rdy_q <= 1'b1;
							if (fill_q < (QW+1)'(QueueDepth)) fill_q <= fill_q + 1'b1;
							else begin
								pst_q <= pcts_pkg::ST_QFULL;
								if (ovf_q != '1) ovf_q <= ovf_q + 1'b1;
							end
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					res_valid <= 1'b1;
					status <= pcts_pkg::ST_OK;
					port_enabled <= 1'b0;
					ready_res <= 1'b0;
					if (fill_q == '0) begin
						frame_valid <= 1'b0;
						last <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						frame_valid <= 1'b1;
						if (sgl_q[hs]) en_q[hs] <= 1'b0;
						fill_q <= fill_q - 1'b1;
						last <= (fill_q == (QW+1)'(1));
						if (fill_q == (QW+1)'(1)) state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					res_valid <= 1'b1;
					status <= pst_q;
					frame_valid <= 1'b0;
					port_enabled <= (cur_q.cmd == pcts_pkg::CMD_QUERY) && rdy_q
						&& pst_q != pcts_pkg::ST_FULL;
					ready_res <= (cur_q.cmd == pcts_pkg::CMD_POLL) && rdy_q;
					last <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/periodic_can_tx_scheduler.sv
// Periodic CAN transmit scheduler top level.
// An accepted transfer waits in the front-end queue until the idle executor takes it. A command then
// holds the executor up to its last result. A port command walks the table one entry per cycle,
// then executes and reports. A poll walks the whole table while auto transmit is enabled and
// then reports. A drain gives one frame per cycle after dispatch. Unknown commands go straight
// to reporting.
// Commands queue in a two-entry buffer; busy is high only when it is full.
// Results appear for one cycle on done; the receiver cannot stall them.
module periodic_can_tx_scheduler #(
	parameter int Ports = pcts_pkg::PortsDef,
	parameter int QueueDepth = pcts_pkg::QueueDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic [2:0] cmd,
	input logic [10:0] tx_id,
	input logic [15:0] period_ms,
	input logic [7:0] start_index,
	input logic [3:0] byte_count,
	input logic [63:0] data,
	input logic enable_value,
	input logic single_mode,
	input logic [31:0] now_us,
	output logic done,
	output logic [1:0] status,
	output logic frame_valid,
	output logic [10:0] frame_id,
	output logic [63:0] frame_data,
	output logic [31:0] interval_us,
	output logic port_enabled,
	output logic ready_res,
	output logic last,
	output logic [15:0] error_count
);
	logic auto_q;
	pcts_pkg::cmd_item_t item, head;
	logic hv, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) auto_q <= 1'b1;
		else if (cfg_we) auto_q <= cfg_wdata;
	end

	assign item = '{cmd, tx_id, period_ms, start_index, byte_count, data,
		enable_value, single_mode, now_us};

	pcts_front #(.Depth(2)) u_front (
		.clk, .arst_n, .start, .busy, .item,
		.item_valid(hv), .item_head(head), .item_pop(pop)
	);

	pcts_back #(.Ports(Ports), .QueueDepth(QueueDepth)) u_back (
		.clk, .arst_n, .auto_tx_enable(auto_q), .item_valid(hv),
		.item_head(head), .item_pop(pop), .res_valid(done), .status,
		.frame_valid, .frame_id, .frame_data, .interval_us, .port_enabled,
		.ready_res, .last, .error_count
	);
endmodule

FILE: hw/rtl/pcts_checker.sv
// Port-level checks for the scheduler.
module pcts_checker (
	input logic clk,
	input logic arst_n,
	input logic done,
	input logic frame_valid,
	input logic port_enabled,
	input logic ready_res,
	input logic [10:0] frame_id,
	input logic [15:0] error_count
);
	a_fv: assert property (@(posedge clk) disable iff (!arst_n)
		done && frame_valid |-> !port_enabled && !ready_res) else $error("frame mix");
	a_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && !frame_valid |-> frame_id == '0) else $error("stray id");
	a_ec: assert property (@(posedge clk) disable iff (!arst_n)
		error_count >= $past(error_count) || $past(!arst_n)) else $error("count fell");
endmodule

bind periodic_can_tx_scheduler pcts_checker u_chk (.clk, .arst_n, .done, .frame_valid,
	.port_enabled, .ready_res, .frame_id, .error_count);
